@@ hw/rtl/mlfq_pkg.sv @@
package mlfq_pkg;

  localparam int unsigned SliceW = 20;
  localparam int unsigned AgeW = 32;
  localparam int unsigned PeriodW = 8;
  localparam int unsigned CfgW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned TimeW = 48;
  localparam int unsigned UsedW = 32;
  localparam int unsigned IdW = 4;
  localparam int unsigned LvlW = 3;
  localparam int unsigned CntW = 5;

  localparam logic [CfgIdxW-1:0] RegSlice = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAge = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPeriod = 2'd2;

  localparam logic [1:0] ReqCreate = 2'd0;
  localparam logic [1:0] ReqTick = 2'd1;
  localparam logic [1:0] ReqWake = 2'd2;

  localparam logic [1:0] StRunning = 2'd0;
  localparam logic [1:0] StYield = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_WR,
    S_AGE_LV,
    S_AGE_RD,
    S_AGE_DO,
    S_CUR_RD,
    S_CUR_DO,
    S_PICK,
    S_PICK_RD,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/mlfq_ram.sv @@
module mlfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/multilevel_feedback_scheduler_core.sv @@
// Multilevel feedback queue scheduler over LEVELS levels and up to MAX_THREADS threads.
// A word is taken at a clock edge where start is high and busy is low. Exactly one
// result word follows it, shown for one cycle with done high. The receiver cannot stall
// it and must take it in that cycle. A create or wake reads the thread record and,
// unless it is ignored, writes it back as it pushes the thread. A tick may run an
// aging scan, which walks the thread record memory one entry at a time for every
// thread queued in levels 1 and below.
module multilevel_feedback_scheduler_core #(
  parameter int unsigned LEVELS = 4,
  parameter int unsigned MAX_THREADS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        req_type,
  input  logic [$clog2(MAX_THREADS)-1:0]    thread_id,
  input  logic [1:0]                        run_status,
  input  logic [mlfq_pkg::TimeW-1:0]        now_time,
  input  logic                              cfg_we,
  input  logic [mlfq_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [mlfq_pkg::CfgW-1:0]         cfg_data,
  output logic                              done,
  output logic                              running_valid,
  output logic [$clog2(MAX_THREADS)-1:0]    running_id,
  output logic [mlfq_pkg::LvlW-1:0]         running_level,
  output logic [$clog2(MAX_THREADS+1)-1:0]  ready_count
);
  import mlfq_pkg::*;

  localparam int unsigned TW = $clog2(MAX_THREADS);
  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned QW = $clog2(MAX_THREADS + 1);
  localparam int unsigned RecW = LvlW + UsedW + TimeW;
  localparam logic [LW:0] LvEnd = (LW+1)'(LEVELS);

  logic [SliceW-1:0] slice_time;
  logic [AgeW-1:0] age_threshold;
  logic [PeriodW-1:0] check_period;

  state_t state, state_next;

  logic [1:0] req;
  logic [TW-1:0] tid;
  logic [1:0] status;
  logic [TimeW-1:0] now;
  logic [PeriodW-1:0] tick_counter;
  logic cur_valid;
  logic [TW-1:0] cur_id;
  logic [LvlW-1:0] cur_level;
  logic [MAX_THREADS-1:0] queued;
  logic [TW-1:0] head [LEVELS];
  logic [TW-1:0] tail [LEVELS];
  logic [QW-1:0] count [LEVELS];
  logic [LW:0] lv;
  logic [LW-1:0] lvi;
  logic [QW-1:0] left;
  logic [TW-1:0] t;

  // Thread record memory: level, used time, last run time.
  logic rec_we;
  logic [TW-1:0] rec_waddr, rec_raddr;
  logic [RecW-1:0] rec_wdata, rec_rdata;
  logic [LvlW-1:0] rd_level;
  logic [UsedW-1:0] rd_used;
  logic [TimeW-1:0] rd_last;

  // Link memory.
  logic lnk_we;
  logic [TW-1:0] lnk_waddr, lnk_raddr, lnk_wdata, lnk_rdata;

  // Queue push.
  logic push_en;
  logic [LW-1:0] push_lv;
  logic [TW-1:0] push_id;

  mlfq_ram #(.WIDTH(RecW), .DEPTH(MAX_THREADS)) u_rec (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(rec_raddr), .rdata(rec_rdata)
  );
  mlfq_ram #(.WIDTH(TW), .DEPTH(MAX_THREADS)) u_lnk (
    .clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
    .raddr(lnk_raddr), .rdata(lnk_rdata)
  );

  assign rd_level = rec_rdata[RecW-1 -: LvlW];
  assign rd_used = rec_rdata[UsedW+TimeW-1 -: UsedW];
  assign rd_last = rec_rdata[TimeW-1:0];
  assign lvi = lv[LW-1:0];

  logic tid_ok;
  logic [TimeW-1:0] idle;
  logic aged;
  logic [UsedW:0] used_sum;
  logic [UsedW-1:0] used_new;
  logic [SliceW+LvlW:0] quota;
  logic over_quota;
  logic [LW-1:0] cur_lv, demote_lv;
  logic nonempty;

  assign tid_ok = {1'b0, tid} < (TW+1)'(MAX_THREADS);
  assign idle = (now >= rd_last) ? now - rd_last : '0;
  assign aged = idle >= TimeW'(age_threshold);
  assign used_sum = {1'b0, rd_used} + (UsedW+1)'(slice_time);
  assign used_new = used_sum[UsedW] ? '1 : used_sum[UsedW-1:0];
  assign cur_lv = LW'(rd_level);
  assign quota = slice_time * ((SliceW+LvlW+1)'(cur_lv) + 1'b1);
  assign over_quota = {{(LvlW+1){1'b0}}, used_new} >= (UsedW+LvlW+1)'(quota);
  assign demote_lv = (32'(cur_lv) + 1 < LEVELS) ? cur_lv + 1'b1 : LW'(LEVELS - 1);
  assign nonempty = count[lvi] != '0;

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (start) state_next = S_PUSH_RD;
      S_PUSH_RD: begin
        if (req == ReqTick) state_next = S_AGE_LV;
        else if ((req == ReqCreate || req == ReqWake) && tid_ok &&
                 !queued[t] && !(cur_valid && cur_id == t)) state_next = S_PUSH_WR;
        else state_next = S_DONE;
      end
      S_PUSH_WR: state_next = S_DONE;
      S_AGE_LV: begin
        if (tick_counter < check_period || lv >= LvEnd) state_next = S_CUR_RD;
        else if (left != '0) state_next = S_AGE_RD;
      end
      S_AGE_RD:  state_next = S_AGE_DO;
      S_AGE_DO:  state_next = S_AGE_LV;
      S_CUR_RD:  state_next = cur_valid ? S_CUR_DO : S_PICK;
      S_CUR_DO:  state_next = S_PICK;
      S_PICK: begin
        if (cur_valid || lv >= LvEnd) state_next = S_DONE;
        else if (nonempty) state_next = S_PICK_RD;
      end
      S_PICK_RD: state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory port drive: reads are issued one state ahead of their use.
  always_comb begin
    rec_raddr = t;
    lnk_raddr = head[lvi];
    unique case (state)
      S_AGE_LV, S_PICK: rec_raddr = head[lvi];
      S_CUR_RD:         rec_raddr = cur_id;
      default:          rec_raddr = t;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slice_time <= SliceW'(100000);
      age_threshold <= AgeW'(1000000);
      check_period <= PeriodW'(10);
      tick_counter <= '0;
      cur_valid <= 1'b0;
      queued <= '0;
      done <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        count[i] <= '0;
        head[i] <= '0;
        tail[i] <= '0;
      end
    end else begin
      state <= state_next;
      done <= state == S_DONE;
      if (cfg_we) begin
        unique case (cfg_index)
          RegSlice:  slice_time <= cfg_data[SliceW-1:0];
          RegAge:    age_threshold <= cfg_data[AgeW-1:0];
          RegPeriod: check_period <= cfg_data[PeriodW-1:0];
          default:   ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          req <= req_type;
          tid <= thread_id;
          t <= thread_id;
          status <= run_status;
          now <= now_time;
          lv <= (LW+1)'(1);
        end
        S_PUSH_RD: begin
          if (req == ReqTick) begin
            left <= count[LW'(1)];
          end
        end
        S_AGE_LV: begin
          if (tick_counter < check_period) begin
            tick_counter <= tick_counter + 1'b1;
            lv <= '0;
          end else if (lv >= LvEnd) begin
            tick_counter <= '0;
            lv <= '0;
          end else if (left != '0) begin
            t <= head[lvi];
          end else begin
            lv <= lv + 1'b1;
            if (lv + 1'b1 < LvEnd) left <= count[lvi + 1'b1];
          end
        end
        S_AGE_RD: begin
          if (count[lvi] > QW'(1)) head[lvi] <= lnk_rdata;
          count[lvi] <= count[lvi] - 1'b1;
          left <= left - 1'b1;
        end
        S_PICK: begin
          if (!cur_valid && lv < LvEnd) begin
            if (nonempty) t <= head[lvi];
            else lv <= lv + 1'b1;
          end
        end
        S_PICK_RD: begin
          if (count[lvi] > QW'(1)) head[lvi] <= lnk_rdata;
          count[lvi] <= count[lvi] - 1'b1;
          queued[t] <= 1'b0;
          cur_valid <= 1'b1;
          cur_id <= t;
          cur_level <= rd_level;
        end
        default: ;
      endcase
      if (push_en) begin
        if (count[push_lv] == '0) head[push_lv] <= push_id;
        tail[push_lv] <= push_id;
        count[push_lv] <= count[push_lv] + 1'b1;
        queued[push_id] <= 1'b1;
      end
      if (state == S_CUR_DO && status != StRunning) cur_valid <= 1'b0;
      if (state == S_CUR_DO && status == StRunning && over_quota) cur_valid <= 1'b0;
    end
  end

  always_comb begin
    push_en = 1'b0;
    push_lv = '0;
    push_id = t;
    rec_we = 1'b0;
    rec_waddr = t;
    rec_wdata = rec_rdata;
    unique case (state)
      S_PUSH_WR: begin
        push_en = 1'b1;
        push_lv = (req == ReqCreate) ? '0 : LW'(rd_level);
        rec_we = 1'b1;
        rec_wdata = {LvlW'(push_lv), {UsedW{1'b0}}, rd_last};
      end
      S_AGE_DO: begin
        push_en = 1'b1;
        push_lv = aged ? '0 : lvi;
        rec_we = 1'b1;
        rec_wdata = aged ? {LvlW'(0), {UsedW{1'b0}}, rd_last} : rec_rdata;
      end
      S_CUR_DO: begin
        push_id = cur_id;
        rec_waddr = cur_id;
        rec_we = 1'b1;
        rec_wdata = {rd_level, used_new, rd_last};
        if (status == StYield) begin
          push_en = 1'b1;
          push_lv = cur_lv;
          rec_wdata = {rd_level, {UsedW{1'b0}}, rd_last};
        end else if (status == StRunning && over_quota) begin
          push_en = 1'b1;
          push_lv = demote_lv;
          rec_wdata = {LvlW'(demote_lv), {UsedW{1'b0}}, rd_last};
        end else if (status == StRunning) begin
          // A running thread that keeps running gets a fresh last-run mark.
          rec_wdata = {rd_level, used_new, now};
        end
      end
      S_PICK_RD: begin
        rec_we = 1'b1;
        rec_wdata = {rd_level, rd_used, now};
      end
      default: ;
    endcase
  end

  // After a pop in the same level the count has already dropped in S_AGE_RD.
  assign lnk_we = push_en && count[push_lv] != '0;
  assign lnk_waddr = tail[push_lv];
  assign lnk_wdata = push_id;

  logic [QW-1:0] total;
  always_comb begin
    total = '0;
    for (int i = 0; i < LEVELS; i++) begin
      total = total + count[i];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      running_valid <= cur_valid;
      running_id <= cur_valid ? cur_id : '0;
      running_level <= cur_valid ? cur_level : '0;
      ready_count <= total;
    end
  end

endmodule
